>>> hw/rtl/mlsac_pkg.sv
// mlsac_pkg: shared types and constants for the multi-lane spi adc capture core
// no dependencies; used by every module of the block except mlsac_outq
`default_nettype none

package mlsac_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int NUM_SAMPLES = 5;
    localparam int MISO_W      = 5;
    localparam int TPU_W       = 16;
    localparam int CWU_W       = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TPU_W-1:0] TPU_RESET = 16'd100;
    localparam logic [CWU_W-1:0] CWU_RESET = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT_UNITS = 2'd1;

    // input beat layout
    localparam int S_TDATA_W    = 8;
    localparam int IN_START_BIT = 0;
    localparam int IN_BUSY_BIT  = 1;
    localparam int IN_MISO_LSB  = 2;

    // result beat layout
    localparam int RES_CNV_BIT    = 0;
    localparam int RES_CSN_BIT    = 1;
    localparam int RES_SCK_BIT    = 2;
    localparam int RES_DONE_BIT   = 3;
    localparam int RES_MISS_BIT   = 4;
    localparam int RES_SAMPLE_LSB = 5;
    localparam int RES_USED_W     = RES_SAMPLE_LSB + NUM_SAMPLES * SAMPLE_W;
    localparam int M_TDATA_W      = ((RES_USED_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CNV,
        PH_WAIT,
        PH_CSSET,
        PH_SCKH,
        PH_SCKL,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic cnv;
        logic cs_n;
        logic sck;
    } pins_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
    } lane_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/multi_lane_spi_adc_capture_core.sv
// multi_lane_spi_adc_capture_core: top level of the multi-lane spi adc capture block
// depends on mlsac_pkg, mlsac_seq, mlsac_lane and mlsac_outq
//
// Each input beat is one tick of the adc pin sequencer: start request, busy pin
// and the five miso lane levels. Every accepted beat yields exactly one output
// beat with the cnv, cs_n and sck drives, the done pulse, the held miss flag and
// the five held signed 16-bit samples (new samples appear with done).
// A run: cnv for one unit, conv_wait_units units, busy check (busy skips to the tail), one cs unit,
// FRAME_BITS sck periods of two units, one tail unit; a unit is ticks_per_unit beats.
// Throughput: one beat per cycle while s_axis_tready is high; the sequencer step and
// all lanes finish in the accepting cycle, and the result beat is then registered
// in a two-entry result queue that sits before the m_ channel;
// when the receiver stalls it fills and s_axis_tready drops once both entries
// are taken, with no beat lost. Configuration writes through cfg_wr_en,
// cfg_index and cfg_data take effect at once and belong to idle periods.
// Reset (synchronous, active low) restores ticks_per_unit 100, conv_wait_units 5,
// puts the sequencer in idle and clears the capture and held sample registers.
`default_nettype none

module multi_lane_spi_adc_capture_core #(
    parameter int LANES      = 5,
    parameter int FRAME_BITS = 24
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mlsac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mlsac_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // start_req, busy_in, miso_lanes[4:0], zero pad
    input  wire logic [mlsac_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // cnv_out, cs_n_out, sck_out, done_res, busy_miss, sample0..sample4, zero pad
    output logic [mlsac_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

    logic [mlsac_pkg::TPU_W-1:0]     ticks_per_unit_reg, ticks_per_unit_next;
    logic [mlsac_pkg::CWU_W-1:0]     conv_wait_units_reg, conv_wait_units_next;

    logic                            s_fire;
    logic                            start_req;
    logic                            busy_in;
    logic [mlsac_pkg::MISO_W-1:0]    miso_lanes;
    mlsac_pkg::pins_t                pins;
    mlsac_pkg::lane_ctl_t            lane_ctl;
    logic                            done;
    logic                            miss;
    logic [mlsac_pkg::SAMPLE_W-1:0]  samples [mlsac_pkg::NUM_SAMPLES];
    logic [mlsac_pkg::M_TDATA_W-1:0] res_data;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign start_req  = s_axis_tdata[mlsac_pkg::IN_START_BIT];
    assign busy_in    = s_axis_tdata[mlsac_pkg::IN_BUSY_BIT];
    assign miso_lanes = s_axis_tdata[mlsac_pkg::IN_MISO_LSB +: mlsac_pkg::MISO_W];

    always_comb begin
        ticks_per_unit_next  = ticks_per_unit_reg;
        conv_wait_units_next = conv_wait_units_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mlsac_pkg::CFG_TICKS_PER_UNIT:  ticks_per_unit_next  = cfg_data;
                mlsac_pkg::CFG_CONV_WAIT_UNITS: conv_wait_units_next =
                    cfg_data[mlsac_pkg::CWU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_unit_reg  <= mlsac_pkg::TPU_RESET;
            conv_wait_units_reg <= mlsac_pkg::CWU_RESET;
        end else begin
            ticks_per_unit_reg  <= ticks_per_unit_next;
            conv_wait_units_reg <= conv_wait_units_next;
        end
    end

    mlsac_seq #(
        .FRAME_BITS (FRAME_BITS)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (s_fire),
        .start_req       (start_req),
        .busy_in         (busy_in),
        .ticks_per_unit  (ticks_per_unit_reg),
        .conv_wait_units (conv_wait_units_reg),
        .pins            (pins),
        .lane_ctl        (lane_ctl),
        .done            (done),
        .miss            (miss)
    );

    for (genvar k = 0; k < mlsac_pkg::NUM_SAMPLES; k++) begin : g_lane
        if (k < LANES) begin : g_on
            mlsac_lane #(
                .FRAME_BITS (FRAME_BITS)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (lane_ctl),
                .miso    (miso_lanes[k]),
                .sample  (samples[k])
            );
        end else begin : g_off
            assign samples[k] = '0;
        end
    end

    // merge pins, flags and lane samples into one result beat
    always_comb begin
        res_data                          = '0;
        res_data[mlsac_pkg::RES_CNV_BIT]  = pins.cnv;
        res_data[mlsac_pkg::RES_CSN_BIT]  = pins.cs_n;
        res_data[mlsac_pkg::RES_SCK_BIT]  = pins.sck;
        res_data[mlsac_pkg::RES_DONE_BIT] = done;
        res_data[mlsac_pkg::RES_MISS_BIT] = miss;
        for (int i = 0; i < mlsac_pkg::NUM_SAMPLES; i++) begin
            res_data[mlsac_pkg::RES_SAMPLE_LSB + i * mlsac_pkg::SAMPLE_W +: mlsac_pkg::SAMPLE_W] =
                samples[i];
        end
    end

    mlsac_outq #(
        .WIDTH (mlsac_pkg::M_TDATA_W)
    ) u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_fire),
        .push_data  (res_data),
        .push_ready (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // cnv and an active chip select never share a tick
    a_cnv_cs_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && res_data[mlsac_pkg::RES_CNV_BIT] |-> res_data[mlsac_pkg::RES_CSN_BIT])
        else $error("cnv high while chip select active");

    // sck only toggles with chip select low
    a_sck_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && res_data[mlsac_pkg::RES_SCK_BIT] |-> !res_data[mlsac_pkg::RES_CSN_BIT])
        else $error("sck high with chip select inactive");

    // done never pulses on accepted beats in two consecutive cycles
    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && done |=> !(s_fire && done))
        else $error("done pulse repeated");

    // lane registers neither shift nor clear on the done beat
    a_miss_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && done |-> !lane_ctl.shift && !lane_ctl.clear)
        else $error("lane update on done beat");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mlsac_seq.sv
// mlsac_seq: pin sequencer, unit timer, wait counter and bit counter
// depends on mlsac_pkg
`default_nettype none

module mlsac_seq #(
    parameter int FRAME_BITS = 24
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           fire,
    input  wire logic                           start_req,
    input  wire logic                           busy_in,
    input  wire logic [mlsac_pkg::TPU_W-1:0]    ticks_per_unit,
    input  wire logic [mlsac_pkg::CWU_W-1:0]    conv_wait_units,
    output mlsac_pkg::pins_t                    pins,
    output mlsac_pkg::lane_ctl_t                lane_ctl,
    output logic                                done,
    output logic                                miss
);

    localparam int BIT_W = $clog2(FRAME_BITS);

    mlsac_pkg::phase_t                 phase_reg, phase_next;
    logic [mlsac_pkg::TPU_W-1:0]       unit_timer_reg, unit_timer_next;
    logic [mlsac_pkg::CWU_W-1:0]       unit_count_reg, unit_count_next;
    logic [BIT_W-1:0]                  bit_index_reg, bit_index_next;
    logic                              miss_reg, miss_next;

    logic [mlsac_pkg::TPU_W-1:0]       tpu_eff;
    logic [mlsac_pkg::TPU_W:0]         timer_inc;
    logic                              unit_last;
    logic [mlsac_pkg::CWU_W-1:0]       count_inc;
    logic [mlsac_pkg::CWU_W-1:0]       need;
    logic                              wait_over;

    assign tpu_eff   = (ticks_per_unit == '0) ? mlsac_pkg::TPU_W'(1) : ticks_per_unit;
    assign timer_inc = {1'b0, unit_timer_reg} + (mlsac_pkg::TPU_W + 1)'(1);
    assign unit_last = (timer_inc >= {1'b0, tpu_eff});
    assign count_inc = unit_count_reg + mlsac_pkg::CWU_W'(1);
    assign need      = (conv_wait_units == '0) ? mlsac_pkg::CWU_W'(1) : conv_wait_units;
    assign wait_over = (count_inc >= need) || (count_inc == '0);

    always_comb begin
        phase_next      = phase_reg;
        unit_timer_next = unit_timer_reg;
        unit_count_next = unit_count_reg;
        bit_index_next  = bit_index_reg;
        miss_next       = miss_reg;
        if (phase_reg != mlsac_pkg::PH_IDLE) begin
            unit_timer_next = unit_last ? '0 : timer_inc[mlsac_pkg::TPU_W-1:0];
        end
        unique case (phase_reg)
            mlsac_pkg::PH_IDLE: begin
                if (start_req) begin
                    unit_timer_next = '0;
                    unit_count_next = '0;
                    phase_next      = mlsac_pkg::PH_CNV;
                end
            end
            mlsac_pkg::PH_CNV: begin
                if (unit_last) begin
                    unit_count_next = '0;
                    phase_next      = mlsac_pkg::PH_WAIT;
                end
            end
            mlsac_pkg::PH_WAIT: begin
                if (unit_last) begin
                    unit_count_next = count_inc;
                    if (wait_over) begin
                        unit_count_next = '0;
                        miss_next       = busy_in;
                        phase_next      = busy_in ? mlsac_pkg::PH_TAIL : mlsac_pkg::PH_CSSET;
                    end
                end
            end
            mlsac_pkg::PH_CSSET: begin
                if (unit_last) begin
                    bit_index_next = BIT_W'(FRAME_BITS - 1);
                    phase_next     = mlsac_pkg::PH_SCKH;
                end
            end
            mlsac_pkg::PH_SCKH: begin
                if (unit_last) begin
                    phase_next = mlsac_pkg::PH_SCKL;
                end
            end
            mlsac_pkg::PH_SCKL: begin
                if (unit_last) begin
                    if (bit_index_reg == '0) begin
                        phase_next = mlsac_pkg::PH_TAIL;
                    end else begin
                        bit_index_next = bit_index_reg - BIT_W'(1);
                        phase_next     = mlsac_pkg::PH_SCKH;
                    end
                end
            end
            mlsac_pkg::PH_TAIL: begin
                if (unit_last) begin
                    phase_next = mlsac_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = mlsac_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        pins.cnv  = 1'b0;
        pins.cs_n = 1'b1;
        pins.sck  = 1'b0;
        unique case (phase_reg)
            mlsac_pkg::PH_CNV:   pins.cnv  = 1'b1;
            mlsac_pkg::PH_CSSET: pins.cs_n = 1'b0;
            mlsac_pkg::PH_SCKH: begin
                pins.cs_n = 1'b0;
                pins.sck  = 1'b1;
            end
            mlsac_pkg::PH_SCKL:  pins.cs_n = 1'b0;
            mlsac_pkg::PH_TAIL:  pins.cs_n = miss_reg;
            default: begin
            end
        endcase
        done           = (phase_reg == mlsac_pkg::PH_TAIL) && unit_last;
        miss           = miss_next;
        lane_ctl.clear = fire && (phase_reg == mlsac_pkg::PH_IDLE) && start_req;
        lane_ctl.shift = fire && (phase_reg == mlsac_pkg::PH_SCKH) && unit_last;
        lane_ctl.load  = fire && done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= mlsac_pkg::PH_IDLE;
            unit_timer_reg <= '0;
            unit_count_reg <= '0;
            bit_index_reg  <= '0;
            miss_reg       <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            unit_timer_reg <= unit_timer_next;
            unit_count_reg <= unit_count_next;
            bit_index_reg  <= bit_index_next;
            miss_reg       <= miss_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mlsac_lane.sv
// mlsac_lane: one capture lane, msb-first shift register and held sample
// depends on mlsac_pkg
`default_nettype none

module mlsac_lane #(
    parameter int FRAME_BITS = 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire mlsac_pkg::lane_ctl_t              ctl,
    input  wire logic                              miso,
    output logic [mlsac_pkg::SAMPLE_W-1:0]         sample
);

    logic [FRAME_BITS-1:0]             lane_shift_reg, lane_shift_next;
    logic [mlsac_pkg::SAMPLE_W-1:0]    held_reg, held_next;

    always_comb begin
        lane_shift_next = lane_shift_reg;
        held_next       = held_reg;
        if (ctl.clear) begin
            lane_shift_next = '0;
        end else if (ctl.shift) begin
            lane_shift_next = {lane_shift_reg[FRAME_BITS-2:0], miso};
        end
        if (ctl.load) begin
            held_next = lane_shift_reg[FRAME_BITS-1 -: mlsac_pkg::SAMPLE_W];
        end
    end

    // sample reflects this beat's update
    assign sample = held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_shift_reg <= '0;
            held_reg       <= '0;
        end else begin
            lane_shift_reg <= lane_shift_next;
            held_reg       <= held_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mlsac_outq.sv
// mlsac_outq: two-entry result queue between the sequencer and the output channel
// depends on nothing but its width parameter
`default_nettype none

module mlsac_outq #(
    parameter int WIDTH = 88
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    output logic                   push_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [WIDTH-1:0]       out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign out_valid  = (count_reg != 2'd0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/mlsac_tick_checker.sv
// mlsac_tick_checker: follows the s_ and m_ streams and the config port of the capture core,
// predicts one result beat per accepted tick and compares it field by field
// depends on mlsac_pkg
module mlsac_tick_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mlsac_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mlsac_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [mlsac_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [mlsac_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output int                                    mismatch_count,
    output int                                    pending_ticks,
    output logic                                  seq_idle
);
    import mlsac_pkg::*;

    localparam int LANE_BITS = 24;

    typedef logic [M_TDATA_W-1:0] tick_word_t;

    logic [TPU_W-1:0]     tpu_reg;
    logic [CWU_W-1:0]     cwu_reg;
    phase_t               ph;
    logic [15:0]          utimer;
    logic [7:0]           ucount;
    logic [4:0]           bidx;
    logic [LANE_BITS-1:0] lane_reg [NUM_SAMPLES];
    logic [SAMPLE_W-1:0]  held [NUM_SAMPLES];
    logic                 miss;
    tick_word_t           expected_ticks [$];

    // true on the last tick of a delay unit
    function automatic bit unit_done();
        int span;
        span = (tpu_reg == 0) ? 1 : int'(tpu_reg);
        if (int'(utimer) + 1 >= span) begin
            utimer = '0;
            return 1'b1;
        end
        utimer = utimer + 16'd1;
        return 1'b0;
    endfunction

    function automatic tick_word_t sequencer_step(logic start, logic busy,
                                                  logic [MISO_W-1:0] miso);
        tick_word_t res;
        logic cnv, csn, sck, done;
        int need;
        cnv = 1'b0;
        csn = 1'b1;
        sck = 1'b0;
        done = 1'b0;
        // pins follow the phase at the start of the tick
        case (ph)
            PH_CNV: cnv = 1'b1;
            PH_CSSET, PH_SCKL: csn = 1'b0;
            PH_SCKH: begin
                csn = 1'b0;
                sck = 1'b1;
            end
            PH_TAIL: csn = miss;
            default: ;
        endcase
        case (ph)
            PH_IDLE: if (start) begin
                for (int k = 0; k < NUM_SAMPLES; k++) lane_reg[k] = '0;
                utimer = '0;
                ucount = '0;
                ph = PH_CNV;
            end
            PH_CNV: if (unit_done()) begin
                ucount = '0;
                ph = PH_WAIT;
            end
            PH_WAIT: if (unit_done()) begin
                need = (cwu_reg == 0) ? 1 : int'(cwu_reg);
                ucount = ucount + 8'd1;
                if (int'(ucount) >= need || ucount == 0) begin
                    ucount = '0;
                    miss = busy;
                    ph = busy ? PH_TAIL : PH_CSSET;
                end
            end
            PH_CSSET: if (unit_done()) begin
                bidx = 5'(LANE_BITS - 1);
                ph = PH_SCKH;
            end
            PH_SCKH: if (unit_done()) begin
                for (int k = 0; k < NUM_SAMPLES; k++)
                    lane_reg[k][bidx] = lane_reg[k][bidx] | miso[k];
                ph = PH_SCKL;
            end
            PH_SCKL: if (unit_done()) begin
                if (bidx == 0) begin
                    ph = PH_TAIL;
                end else begin
                    bidx = bidx - 5'd1;
                    ph = PH_SCKH;
                end
            end
            PH_TAIL: if (unit_done()) begin
                for (int k = 0; k < NUM_SAMPLES; k++)
                    held[k] = lane_reg[k][LANE_BITS-1 -: SAMPLE_W];
                done = 1'b1;
                ph = PH_IDLE;
            end
            default: ph = PH_IDLE;
        endcase
        res = '0;
        res[RES_CNV_BIT]  = cnv;
        res[RES_CSN_BIT]  = csn;
        res[RES_SCK_BIT]  = sck;
        res[RES_DONE_BIT] = done;
        res[RES_MISS_BIT] = miss;
        for (int k = 0; k < NUM_SAMPLES; k++)
            res[RES_SAMPLE_LSB + SAMPLE_W*k +: SAMPLE_W] = held[k];
        return res;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_tick(input tick_word_t want, input tick_word_t got);
        compare_field("cnv_out", want[RES_CNV_BIT], got[RES_CNV_BIT]);
        compare_field("cs_n_out", want[RES_CSN_BIT], got[RES_CSN_BIT]);
        compare_field("sck_out", want[RES_SCK_BIT], got[RES_SCK_BIT]);
        compare_field("done_res", want[RES_DONE_BIT], got[RES_DONE_BIT]);
        compare_field("busy_miss", want[RES_MISS_BIT], got[RES_MISS_BIT]);
        for (int k = 0; k < NUM_SAMPLES; k++)
            compare_field($sformatf("sample%0d", k),
                          $signed(want[RES_SAMPLE_LSB + SAMPLE_W*k +: SAMPLE_W]),
                          $signed(got[RES_SAMPLE_LSB + SAMPLE_W*k +: SAMPLE_W]));
        compare_field("pad", want[M_TDATA_W-1:RES_USED_W], got[M_TDATA_W-1:RES_USED_W]);
    endtask

    initial mismatch_count = 0;

    always @(posedge aclk) begin
        logic [S_TDATA_W-1:0] din;
        tick_word_t want;
        if (!aresetn) begin
            tpu_reg = TPU_RESET;
            cwu_reg = CWU_RESET;
            ph = PH_IDLE;
            utimer = '0;
            ucount = '0;
            bidx = '0;
            for (int k = 0; k < NUM_SAMPLES; k++) begin
                lane_reg[k] = '0;
                held[k] = '0;
            end
            miss = 1'b0;
            expected_ticks.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_TICKS_PER_UNIT)
                    tpu_reg = cfg_data[TPU_W-1:0];
                else if (cfg_index == CFG_CONV_WAIT_UNITS)
                    cwu_reg = cfg_data[CWU_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                din = s_axis_tdata;
                expected_ticks.push_back(sequencer_step(din[IN_START_BIT], din[IN_BUSY_BIT],
                                                        din[IN_MISO_LSB +: MISO_W]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result beat with no tick waiting");
                    mismatch_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    compare_tick(want, m_axis_tdata);
                end
            end
        end
        pending_ticks <= expected_ticks.size();
        seq_idle <= (ph == PH_IDLE);
    end

endmodule

>>> tb/testbench.sv
// testbench: drives ticks and config writes into multi_lane_spi_adc_capture_core
// under several idle and stall patterns; verdict from mlsac_tick_checker
// depends on mlsac_pkg, mlsac_tick_checker and the capture core rtl
module testbench;
    import mlsac_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int LONG_HOLD_CYCLES = 300;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    int   mismatch_count;
    int   pending_ticks;
    logic seq_idle;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    bit leftover = 1'b0;

    always #5 aclk = ~aclk;

    multi_lane_spi_adc_capture_core #(
        .LANES      (5),
        .FRAME_BITS (24)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mlsac_tick_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_ticks  (pending_ticks),
        .seq_idle       (seq_idle)
    );

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic send_tick(input logic start, input logic busy, input logic [MISO_W-1:0] miso);
        logic [S_TDATA_W-1:0] beat;
        beat = '0;
        beat[IN_START_BIT] = start;
        beat[IN_BUSY_BIT] = busy;
        beat[IN_MISO_LSB +: MISO_W] = miso;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding result beat
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_ticks != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // idle status lags one beat, so at least one beat goes out before it is trusted
    task automatic drain_to_idle();
        do begin
            send_tick(1'b0, 1'($urandom_range(0, 1)), 5'($urandom));
        end while (!seq_idle);
    endtask

    task automatic capture_run();
        bit miss_run;
        int miso_style;
        logic [MISO_W-1:0] lane_bias;
        logic [MISO_W-1:0] miso;
        logic busy;
        miss_run = ($urandom_range(0, 3) == 0);
        miso_style = $urandom_range(0, 3);
        lane_bias = 5'($urandom);
        send_tick(1'b1, miss_run, lane_bias);
        do begin
            busy = ($urandom_range(0, 9) == 0) ? !miss_run : miss_run;
            case (miso_style)
                0: miso = 5'($urandom);
                1: miso = ($urandom_range(0, 1) != 0) ? 5'h1F : 5'h00;
                2: miso = ($urandom_range(0, 15) == 0) ? ~lane_bias : lane_bias;
                default: miso = lane_bias ^ (($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'h00);
            endcase
            send_tick($urandom_range(0, 7) == 0, busy, miso);
        end while (!seq_idle);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [15:0] tpu,
                             input logic [15:0] cwu, input int runs, input bit long_hold);
        quiesce();
        write_reg(CFG_TICKS_PER_UNIT, tpu);
        write_reg(CFG_CONV_WAIT_UNITS, cwu);
        tx_idle_pct <= tx_pct;
        rx_stall_pct <= rx_pct;
        if (long_hold) hold_requests <= hold_requests + 1;
        repeat (runs) capture_run();
        drain_to_idle();
    endtask

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int waited;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle ticks at reset settings, field extremes
        send_tick(1'b0, 1'b1, 5'h1F);
        send_tick(1'b0, 1'b0, 5'h00);
        quiesce();
        write_reg(CFG_TICKS_PER_UNIT, 16'hFFFF);
        write_reg(CFG_CONV_WAIT_UNITS, 16'hFFFF);
        send_tick(1'b0, 1'b1, 5'h15);
        send_tick(1'b0, 1'b0, 5'h0A);
        quiesce();
        // unused indexes must leave both registers alone
        write_reg(CFG_SPARE_A, 16'h0003);
        write_reg(CFG_SPARE_B, 16'h0000);
        write_reg(CFG_TICKS_PER_UNIT, 16'h0001);
        write_reg(CFG_CONV_WAIT_UNITS, 16'h5A01);
        // busy still high at the check, start requests while running
        send_tick(1'b1, 1'b1, 5'h1F);
        send_tick(1'b1, 1'b1, 5'h1F);
        send_tick(1'b0, 1'b1, 5'h00);
        send_tick(1'b1, 1'b1, 5'h1F);
        send_tick(1'b0, 1'b0, 5'h00);
        drain_to_idle();

        run_phase(0, 0, 16'd1, 16'd1, 3, 1'b0);
        run_phase(45, 0, 16'd0, 16'd0, 3, 1'b0);
        run_phase(0, 45, 16'd2, 16'd2, 1, 1'b1);
        run_phase(7, 7, 16'd1, 16'd255, 1, 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending_ticks != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (pending_ticks != 0) begin
            $error("%0d expected result beats never arrived", pending_ticks);
            leftover = 1'b1;
        end
        if (mismatch_count == 0 && !leftover)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
